// ===== hw/rtl/tlv_parameter_engine_assert.svh =====
// Assertion macros shared by the parameter engine RTL.
`ifndef TLV_PARAMETER_ENGINE_ASSERT_SVH
`define TLV_PARAMETER_ENGINE_ASSERT_SVH

// Check a condition on every rising clock edge outside reset.
`define TLV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define TLV_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tlv_pkg.sv =====
// Package with types and constants of the TLV parameter engine.
`default_nettype none

package tlv_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT  = 2'd2;

    // Operating modes
    localparam logic MODE_FETCH = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Outcome codes
    localparam logic OUTCOME_OK   = 1'b0;
    localparam logic OUTCOME_FAIL = 1'b1;

    // Reset values of the configuration registers
    localparam logic              RST_OP_MODE     = MODE_FETCH;
    localparam logic [BYTE_W-1:0] RST_RECORD_CODE = 8'd1;
    localparam logic [BYTE_W-1:0] RST_BYTE_LIMIT  = 8'd0;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_LEN_HIT  = 3'd1,
        PH_LEN_SKIP = 3'd2,
        PH_VALUE    = 3'd3,
        PH_SKIP     = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [BYTE_W-1:0] record_left;
        logic [BYTE_W-1:0] limit_left;
        logic              block_done;
    } scan_state_t;

    typedef struct packed {
        logic              op_mode;
        logic [BYTE_W-1:0] record_code;
        logic [BYTE_W-1:0] byte_limit;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] block_byte;
        logic [BYTE_W-1:0] new_value_byte;
        logic              end_of_block;
    } in_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic              store_back;
        logic              value_out;
        logic              value_taken;
        logic              finished;
        logic              outcome;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlv_parameter_engine.sv =====
// A beat is held in the input register, its result in the result register; the scan step between
// them sets the throughput: one block byte per cycle while the result channel does not stall.
// The input stage advances whenever the result register is empty or being taken.
// Reset: pipeline valids and scan state clear, registers return to fetch mode,
// record code 1 and byte limit 0.
`default_nettype none

module tlv_parameter_engine (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration write port
    input  wire                              cfg_we,
    input  wire [tlv_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire [tlv_pkg::BYTE_W-1:0]        cfg_wdata,
    // input channel
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire [tlv_pkg::BYTE_W-1:0]        block_byte,
    input  wire [tlv_pkg::BYTE_W-1:0]        new_value_byte,
    input  wire                              end_of_block,
    // result channel
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [tlv_pkg::BYTE_W-1:0]       result_byte,
    output logic                             store_back,
    output logic                             value_out,
    output logic                             value_taken,
    output logic                             finished,
    output logic                             outcome
);

    tlv_pkg::cfg_t        cfg_reg;
    tlv_pkg::scan_state_t state_reg;
    tlv_pkg::scan_state_t state_next;
    tlv_pkg::in_beat_t    in_beat_reg;
    logic                 in_valid_reg;
    tlv_pkg::out_beat_t   out_beat_reg;
    tlv_pkg::out_beat_t   out_beat_next;
    logic                 out_valid_reg;
    logic                 advance;

    // move the held beat on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    tlv_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .beat       (in_beat_reg),
        .state_next (state_next),
        .result     (out_beat_next)
    );

    // configuration registers; a byte limit write also reloads the limit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode     <= tlv_pkg::RST_OP_MODE;
            cfg_reg.record_code <= tlv_pkg::RST_RECORD_CODE;
            cfg_reg.byte_limit  <= tlv_pkg::RST_BYTE_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tlv_pkg::CFG_OP_MODE:     cfg_reg.op_mode     <= cfg_wdata[0];
                tlv_pkg::CFG_RECORD_CODE: cfg_reg.record_code <= cfg_wdata;
                tlv_pkg::CFG_BYTE_LIMIT:  cfg_reg.byte_limit  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // scan state advances once per beat leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= tlv_pkg::PH_START;
            state_reg.record_left <= '0;
            state_reg.limit_left  <= tlv_pkg::RST_BYTE_LIMIT;
            state_reg.block_done  <= 1'b0;
        end
        else if (cfg_we && cfg_addr == tlv_pkg::CFG_BYTE_LIMIT)
            state_reg.limit_left <= cfg_wdata;
        else if (advance)
            state_reg <= state_next;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_beat_reg.block_byte     <= block_byte;
            in_beat_reg.new_value_byte <= new_value_byte;
            in_beat_reg.end_of_block   <= end_of_block;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_beat_reg <= out_beat_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = out_beat_reg.result_byte;
    assign store_back  = out_beat_reg.store_back;
    assign value_out   = out_beat_reg.value_out;
    assign value_taken = out_beat_reg.value_taken;
    assign finished    = out_beat_reg.finished;
    assign outcome     = out_beat_reg.outcome;

`include "tlv_parameter_engine_assert.svh"

    `TLV_ASSERT_ALWAYS(a_fetch_store_excl,
        !(out_valid_reg && value_out && store_back),
        "value_out and store_back together")
    `TLV_ASSERT_IMPLY(a_taken_stores, out_valid_reg && value_taken, store_back,
        "value consumed without store")
    `TLV_ASSERT_IMPLY(a_outcome_final, out_valid_reg && outcome, finished,
        "outcome set on an undecided beat")
    `TLV_ASSERT_IMPLY(a_stall_cause, !in_ready,
        in_valid_reg && out_valid_reg && !out_ready,
        "input stalled without a full pipeline")

endmodule

`default_nettype wire

// ===== hw/rtl/tlv_step.sv =====
// Combinational scan step: next scan state and result for one block byte.
`default_nettype none

module tlv_step (
    input  var tlv_pkg::cfg_t        cfg,
    input  var tlv_pkg::scan_state_t state,
    input  var tlv_pkg::in_beat_t    beat,
    output tlv_pkg::scan_state_t     state_next,
    output tlv_pkg::out_beat_t       result
);

    logic [tlv_pkg::BYTE_W-1:0] rec_dec;
    logic [tlv_pkg::BYTE_W-1:0] lim_dec;

    assign rec_dec = state.record_left - 8'd1;
    assign lim_dec = state.limit_left - 8'd1;

    always_comb
    begin
        logic fin;
        logic oc;
        logic [tlv_pkg::BYTE_W-1:0] b;

        b          = beat.block_byte;
        state_next = state;
        result     = '0;
        fin        = 1'b0;
        oc         = tlv_pkg::OUTCOME_OK;

        if (!state.block_done)
        begin
            if (state.phase == tlv_pkg::PH_START && cfg.record_code == 8'd0)
            begin
                // code zero can never be found or written
                fin = 1'b1;
                oc  = tlv_pkg::OUTCOME_FAIL;
            end
            else if (cfg.op_mode == tlv_pkg::MODE_FETCH)
            begin
                case (state.phase)
                    tlv_pkg::PH_START:
                    begin
                        if (b == 8'd0)
                        begin
                            fin = 1'b1;
                            oc  = tlv_pkg::OUTCOME_FAIL;
                        end
                        else if (b == cfg.record_code)
                            state_next.phase = tlv_pkg::PH_LEN_HIT;
                        else
                            state_next.phase = tlv_pkg::PH_LEN_SKIP;
                    end
                    tlv_pkg::PH_LEN_HIT:
                    begin
                        state_next.record_left = b;
                        if (b == 8'd0 || state.limit_left == 8'd0)
                            fin = 1'b1;
                        else
                            state_next.phase = tlv_pkg::PH_VALUE;
                    end
                    tlv_pkg::PH_LEN_SKIP:
                    begin
                        state_next.record_left = b;
                        state_next.phase = (b != 8'd0) ? tlv_pkg::PH_SKIP : tlv_pkg::PH_START;
                    end
                    tlv_pkg::PH_VALUE:
                    begin
                        if (state.record_left != 8'd0 && state.limit_left != 8'd0)
                        begin
                            result.result_byte = b;
                            result.value_out   = 1'b1;
                            state_next.record_left = rec_dec;
                            state_next.limit_left  = lim_dec;
                            if (rec_dec == 8'd0 || lim_dec == 8'd0)
                                fin = 1'b1;
                        end
                        else
                            fin = 1'b1;
                    end
                    tlv_pkg::PH_SKIP:
                    begin
                        state_next.record_left = rec_dec;
                        if (rec_dec == 8'd0)
                            state_next.phase = tlv_pkg::PH_START;
                    end
                    default:
                        state_next.phase = tlv_pkg::PH_START;
                endcase
            end
            else
            begin
                case (state.phase)
                    tlv_pkg::PH_START:
                    begin
                        // the terminator slot takes the new code
                        if (b == 8'd0)
                        begin
                            result.result_byte = cfg.record_code;
                            result.store_back  = 1'b1;
                            state_next.phase   = tlv_pkg::PH_LEN_HIT;
                        end
                        else
                            state_next.phase = tlv_pkg::PH_LEN_SKIP;
                    end
                    tlv_pkg::PH_LEN_HIT:
                    begin
                        result.result_byte = state.limit_left;
                        result.store_back  = 1'b1;
                        state_next.record_left = state.limit_left;
                        state_next.phase = tlv_pkg::PH_VALUE;
                        if (beat.end_of_block)
                        begin
                            fin = 1'b1;
                            oc  = (state.limit_left != 8'd0);
                        end
                    end
                    tlv_pkg::PH_LEN_SKIP:
                    begin
                        state_next.record_left = b;
                        state_next.phase = (b != 8'd0) ? tlv_pkg::PH_SKIP : tlv_pkg::PH_START;
                    end
                    tlv_pkg::PH_VALUE:
                    begin
                        result.store_back = 1'b1;
                        if (state.limit_left != 8'd0)
                        begin
                            result.result_byte  = beat.new_value_byte;
                            result.value_taken  = 1'b1;
                            state_next.limit_left  = lim_dec;
                            state_next.record_left = rec_dec;
                            if (beat.end_of_block)
                            begin
                                fin = 1'b1;
                                oc  = (lim_dec != 8'd0);
                            end
                        end
                        else
                            // new terminator after the last value byte
                            fin = 1'b1;
                    end
                    tlv_pkg::PH_SKIP:
                    begin
                        state_next.record_left = rec_dec;
                        if (rec_dec == 8'd0)
                            state_next.phase = tlv_pkg::PH_START;
                    end
                    default:
                        state_next.phase = tlv_pkg::PH_START;
                endcase
            end

            // block ran out before a decision
            if (beat.end_of_block && !fin)
            begin
                fin = 1'b1;
                oc  = tlv_pkg::OUTCOME_FAIL;
            end
        end

        if (fin)
            state_next.block_done = 1'b1;

        // rearm for the next block
        if (beat.end_of_block)
        begin
            state_next.phase       = tlv_pkg::PH_START;
            state_next.record_left = 8'd0;
            state_next.limit_left  = cfg.byte_limit;
            state_next.block_done  = 1'b0;
        end

        result.finished = fin;
        result.outcome  = fin ? oc : tlv_pkg::OUTCOME_OK;
    end

endmodule

`default_nettype wire

// ===== test/tlv_parameter_engine_tb.sv =====
// Self-checking testbench for the TLV parameter engine: directed and random blocks.
`timescale 1ns / 1ps

module tlv_parameter_engine_tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SHAPE_CLEAN   = 0;
    localparam int SHAPE_BROKEN  = 1;
    localparam int SHAPE_NOISE   = 2;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [tlv_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [tlv_pkg::BYTE_W-1:0]    cfg_wdata;
    logic                          in_valid;
    logic                          in_ready;
    logic [tlv_pkg::BYTE_W-1:0]    block_byte;
    logic [tlv_pkg::BYTE_W-1:0]    new_value_byte;
    logic                          end_of_block;
    logic                          out_valid;
    logic                          out_ready;
    logic [tlv_pkg::BYTE_W-1:0]    result_byte;
    logic                          store_back;
    logic                          value_out;
    logic                          value_taken;
    logic                          finished;
    logic                          outcome;

    // Scanner mirror: live registers and parse state
    tlv_pkg::cfg_t              live_cfg;
    tlv_pkg::phase_t            scan_ph;
    logic [tlv_pkg::BYTE_W-1:0] rec_left;
    logic [tlv_pkg::BYTE_W-1:0] lim_left;
    logic                       blk_done;

    tlv_pkg::out_beat_t pending_results[$];
    tlv_pkg::in_beat_t  block_q[$];
    tlv_pkg::out_beat_t want;
    int                 live_beats;
    int                 mismatch_count;
    int                 orphan_count;
    int                 cycle_count;
    bit                 idle_on;

    tlv_parameter_engine DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .block_byte     (block_byte),
        .new_value_byte (new_value_byte),
        .end_of_block   (end_of_block),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_byte    (result_byte),
        .store_back     (store_back),
        .value_out      (value_out),
        .value_taken    (value_taken),
        .finished       (finished),
        .outcome        (outcome)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Advance the scanner mirror by one block byte and return the result it gives
    function automatic tlv_pkg::out_beat_t scan_byte(input tlv_pkg::in_beat_t beat);
        tlv_pkg::out_beat_t         r;
        logic                       fin;
        logic                       fail;
        logic [tlv_pkg::BYTE_W-1:0] b;
        r    = '0;
        fin  = 1'b0;
        fail = 1'b0;
        b    = beat.block_byte;
        if (!blk_done)
        begin
            if (scan_ph == tlv_pkg::PH_START && live_cfg.record_code == 8'd0)
            begin
                fin  = 1'b1;
                fail = 1'b1;
            end
            else
            begin
                case (scan_ph)
                    tlv_pkg::PH_START:
                    begin
                        if (live_cfg.op_mode == tlv_pkg::MODE_FETCH)
                        begin
                            if (b == 8'd0)
                            begin
                                fin  = 1'b1;
                                fail = 1'b1;
                            end
                            else
                            begin
                                scan_ph = (b == live_cfg.record_code) ? tlv_pkg::PH_LEN_HIT
                                                                      : tlv_pkg::PH_LEN_SKIP;
                            end
                        end
                        else if (b == 8'd0)
                        begin
                            r.result_byte = live_cfg.record_code;
                            r.store_back  = 1'b1;
                            scan_ph       = tlv_pkg::PH_LEN_HIT;
                        end
                        else
                        begin
                            scan_ph = tlv_pkg::PH_LEN_SKIP;
                        end
                    end
                    tlv_pkg::PH_LEN_HIT:
                    begin
                        if (live_cfg.op_mode == tlv_pkg::MODE_FETCH)
                        begin
                            rec_left = b;
                            if (b == 8'd0 || lim_left == 8'd0)
                                fin = 1'b1;
                            else
                                scan_ph = tlv_pkg::PH_VALUE;
                        end
                        else
                        begin
                            r.result_byte = lim_left;
                            r.store_back  = 1'b1;
                            rec_left      = lim_left;
                            scan_ph       = tlv_pkg::PH_VALUE;
                            if (beat.end_of_block)
                            begin
                                fin  = 1'b1;
                                fail = (lim_left != 8'd0);
                            end
                        end
                    end
                    tlv_pkg::PH_LEN_SKIP:
                    begin
                        rec_left = b;
                        scan_ph  = (b != 8'd0) ? tlv_pkg::PH_SKIP : tlv_pkg::PH_START;
                    end
                    tlv_pkg::PH_VALUE:
                    begin
                        if (live_cfg.op_mode == tlv_pkg::MODE_FETCH)
                        begin
                            if (rec_left != 8'd0 && lim_left != 8'd0)
                            begin
                                r.result_byte = b;
                                r.value_out   = 1'b1;
                                rec_left      = rec_left - 8'd1;
                                lim_left      = lim_left - 8'd1;
                                if (rec_left == 8'd0 || lim_left == 8'd0)
                                    fin = 1'b1;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        else if (lim_left != 8'd0)
                        begin
                            r.result_byte = beat.new_value_byte;
                            r.store_back  = 1'b1;
                            r.value_taken = 1'b1;
                            lim_left      = lim_left - 8'd1;
                            rec_left      = rec_left - 8'd1;
                            if (beat.end_of_block)
                            begin
                                fin  = 1'b1;
                                fail = (lim_left != 8'd0);
                            end
                        end
                        else
                        begin
                            // drop the new terminator in
                            r.store_back = 1'b1;
                            fin          = 1'b1;
                        end
                    end
                    tlv_pkg::PH_SKIP:
                    begin
                        rec_left = rec_left - 8'd1;
                        if (rec_left == 8'd0)
                            scan_ph = tlv_pkg::PH_START;
                    end
                    default:
                    begin
                        scan_ph = tlv_pkg::PH_START;
                    end
                endcase
            end
            if (beat.end_of_block && !fin)
            begin
                fin  = 1'b1;
                fail = 1'b1;
            end
        end
        if (fin)
            blk_done = 1'b1;
        // Rearm at the block boundary
        if (beat.end_of_block)
        begin
            scan_ph  = tlv_pkg::PH_START;
            rec_left = 8'd0;
            lim_left = live_cfg.byte_limit;
            blk_done = 1'b0;
        end
        r.finished = fin;
        r.outcome  = (fin && fail) ? tlv_pkg::OUTCOME_FAIL : tlv_pkg::OUTCOME_OK;
        return r;
    endfunction

    // Write one register while the engine is idle, and mirror it
    task automatic write_reg(input logic [tlv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tlv_pkg::BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tlv_pkg::CFG_OP_MODE)
        begin
            live_cfg.op_mode = val[0];
        end
        else if (idx == tlv_pkg::CFG_RECORD_CODE)
        begin
            live_cfg.record_code = val;
        end
        else if (idx == tlv_pkg::CFG_BYTE_LIMIT)
        begin
            live_cfg.byte_limit = val;
            lim_left            = val;
        end
        @(negedge clk);
    endtask

    // Offer one beat, hold it until taken, then log the result it should give
    task automatic send_beat(input tlv_pkg::in_beat_t beat);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid       <= 1'b1;
        block_byte     <= beat.block_byte;
        new_value_byte <= beat.new_value_byte;
        end_of_block   <= beat.end_of_block;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        live_beats++;
        pending_results.insert(pending_results.size(), scan_byte(beat));
        @(negedge clk);
    endtask

    task automatic push_byte(input logic [tlv_pkg::BYTE_W-1:0] b,
                             input logic [tlv_pkg::BYTE_W-1:0] nv);
        tlv_pkg::in_beat_t bt;
        bt.block_byte     = b;
        bt.new_value_byte = nv;
        bt.end_of_block   = 1'b0;
        block_q.insert(block_q.size(), bt);
    endtask

    // Mark the last byte and stream the whole block
    task automatic send_block();
        block_q[block_q.size() - 1].end_of_block = 1'b1;
        foreach (block_q[i])
            send_beat(block_q[i]);
        block_q.delete();
    endtask

    // Drop valid, drain every pending result, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Build a block: well-formed records, a truncated one, or raw noise
    task automatic make_block(input int shape);
        int len;
        int trail;
        int cut;
        block_q.delete();
        if (shape == SHAPE_NOISE)
        begin
            repeat ($urandom_range(1, 12))
                push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                push_byte(($urandom_range(0, 2) == 0) ? live_cfg.record_code
                                                      : 8'($urandom_range(1, 255)),
                          8'($urandom_range(0, 255)));
                case ($urandom_range(0, 59))
                    0:       len = $urandom_range(200, 255);
                    1, 2, 3,
                    4, 5, 6: len = 0;
                    default: len = $urandom_range(1, 6);
                endcase
                push_byte(8'(len), 8'($urandom_range(0, 255)));
                repeat (len)
                    push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            push_byte(8'd0, 8'($urandom_range(0, 255)));
            // leave room for the new record most of the time in write mode
            if (live_cfg.op_mode == tlv_pkg::MODE_WRITE)
                trail = ($urandom_range(0, 2) != 0)
                      ? live_cfg.byte_limit + 2 + $urandom_range(0, 2)
                      : $urandom_range(0, live_cfg.byte_limit + 1);
            else
                trail = $urandom_range(0, 3);
            repeat (trail)
                push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            if (shape == SHAPE_BROKEN && block_q.size() > 1)
            begin
                cut = $urandom_range(1, block_q.size() - 1);
                while (block_q.size() > cut)
                    void'(block_q.pop_back());
            end
        end
    endtask

    // Reset defaults: fetch code 1 with a zero limit finishes on the length byte
    task automatic test_reset_values();
        push_byte(8'h01, 8'h00);
        push_byte(8'h02, 8'h00);
        push_byte(8'h33, 8'h00);
        send_block();
        wait_idle();
    endtask

    // Skip a zero-length record, then fetch until the limit stops it
    task automatic test_fetch_record();
        write_reg(tlv_pkg::CFG_RECORD_CODE, 8'hFF);
        write_reg(tlv_pkg::CFG_BYTE_LIMIT, 8'd2);
        push_byte(8'h05, 8'h00);
        push_byte(8'h00, 8'h00);
        push_byte(8'hFF, 8'h00);
        push_byte(8'h03, 8'h00);
        push_byte(8'h00, 8'h00);
        push_byte(8'hFF, 8'h00);
        push_byte(8'h80, 8'h00);
        send_block();
        wait_idle();
    endtask

    // Terminator before any hit, and a block that ends undecided
    task automatic test_missing_record();
        write_reg(tlv_pkg::CFG_RECORD_CODE, 8'h7F);
        push_byte(8'h00, 8'h00);
        push_byte(8'h12, 8'h00);
        send_block();
        push_byte(8'h01, 8'h00);
        push_byte(8'h01, 8'h00);
        push_byte(8'h55, 8'h00);
        send_block();
        wait_idle();
    endtask

    // Append with room, without room, and with a zero limit
    task automatic test_append_record();
        write_reg(tlv_pkg::CFG_OP_MODE, 8'(tlv_pkg::MODE_WRITE));
        write_reg(tlv_pkg::CFG_RECORD_CODE, 8'h80);
        write_reg(tlv_pkg::CFG_BYTE_LIMIT, 8'd1);
        push_byte(8'h00, 8'h00);
        push_byte(8'h00, 8'h00);
        push_byte(8'h00, 8'hFF);
        push_byte(8'h00, 8'h00);
        send_block();
        push_byte(8'h00, 8'h00);
        push_byte(8'h00, 8'hFF);
        send_block();
        wait_idle();
        write_reg(tlv_pkg::CFG_BYTE_LIMIT, 8'd0);
        push_byte(8'h00, 8'h00);
        push_byte(8'h09, 8'h00);
        send_block();
        wait_idle();
    endtask

    // Code zero fails on the first byte
    task automatic test_zero_code();
        write_reg(tlv_pkg::CFG_RECORD_CODE, 8'd0);
        push_byte(8'h33, 8'h00);
        send_block();
        wait_idle();
    endtask

    // Random settings, each held for three to eight blocks, or for one block in write mode with a limit above 200
    task automatic test_random_blocks(input int stop_at, input bit allow_idle);
        int pick;
        int n_blocks;
        int shape;
        while (live_beats < stop_at)
        begin
            write_reg(tlv_pkg::CFG_OP_MODE, 8'($urandom_range(0, 1)));
            pick = $urandom_range(0, 4);
            write_reg(tlv_pkg::CFG_RECORD_CODE, (pick == 0) ? 8'd1 : (pick == 1) ? 8'd255
                                               : 8'($urandom_range(1, 255)));
            pick = $urandom_range(0, 9);
            write_reg(tlv_pkg::CFG_BYTE_LIMIT, (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255
                                    : (pick == 2) ? 8'd1 : 8'($urandom_range(0, 8)));
            idle_on  = allow_idle && ($urandom_range(0, 4) != 0);
            n_blocks = (live_cfg.op_mode == tlv_pkg::MODE_WRITE && live_cfg.byte_limit > 8'd200)
                     ? 1 : $urandom_range(3, 8);
            repeat (n_blocks)
            begin
                pick  = $urandom_range(0, 19);
                shape = (pick < 13) ? SHAPE_CLEAN : (pick < 17) ? SHAPE_BROKEN : SHAPE_NOISE;
                make_block(shape);
                send_block();
            end
            wait_idle();
        end
    endtask

    // Result side: stall in random bursts while idling is on
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                orphan_count++;
                if (orphan_count + mismatch_count <= 10)
                    $display("%0t: result beat with nothing pending: byte=%02h", $realtime,
                             result_byte);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.result_byte !== result_byte || want.store_back !== store_back ||
                    want.value_out !== value_out || want.value_taken !== value_taken ||
                    want.finished !== finished || want.outcome !== outcome)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp byte=%02h st=%b vo=%b vt=%b fin=%b oc=%b",
                                 $realtime, want.result_byte, want.store_back, want.value_out,
                                 want.value_taken, want.finished, want.outcome,
                                 " got byte=%02h st=%b vo=%b vt=%b fin=%b oc=%b",
                                 result_byte, store_back, value_out, value_taken,
                                 finished, outcome);
                end
            end
        end
    end

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tlv_parameter_engine test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = tlv_pkg::CFG_OP_MODE;
        cfg_wdata      = 8'd0;
        in_valid       = 1'b0;
        block_byte     = 8'd0;
        new_value_byte = 8'd0;
        end_of_block   = 1'b0;
        idle_on        = 1'b1;
        cycle_count    = 0;
        live_beats     = 0;
        mismatch_count = 0;
        orphan_count   = 0;
        live_cfg.op_mode     = tlv_pkg::RST_OP_MODE;
        live_cfg.record_code = tlv_pkg::RST_RECORD_CODE;
        live_cfg.byte_limit  = tlv_pkg::RST_BYTE_LIMIT;
        scan_ph  = tlv_pkg::PH_START;
        rec_left = 8'd0;
        lim_left = tlv_pkg::RST_BYTE_LIMIT;
        blk_done = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_fetch_record();
        test_missing_record();
        test_append_record();
        test_zero_code();
        test_random_blocks(850, 1'b1);
        test_random_blocks(980, 1'b0);

        if (mismatch_count == 0 && orphan_count == 0 && pending_results.size() == 0)
            $display("tlv_parameter_engine test passed");
        else
            $display("tlv_parameter_engine test failed");
        $finish;
    end

endmodule
